/* rtl/sliding_window_median_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running median filter
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// A condition that must hold at every clock edge.
`define SWM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, reset values and control types of the running median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default window capacity.
  localparam int WINDOW_MAX_DEF = 16;

  // Field widths.
  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 5;

  // Window length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  // Control from the handshake logic to the sorted store.
  typedef struct packed {
    logic step;     // an item is accepted this cycle
    logic restart;  // the window length is written, filling starts over
  } swm_ctrl_t;

endpackage

/* rtl/swm_sorter.sv */
// ----------------------------------------------------------------------------
// swm_sorter
// Sorted sample store with ages. For each new sample the oldest entry is
// dropped when the window is full, the others age, the new sample is inserted
// in order, and the median of the updated window is selected combinationally.
// ----------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module swm_sorter
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  swm_ctrl_t                  ctrl,
  input  logic [LEN_W-1:0]           window_len,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       emit,
  output logic signed [SAMPLE_W-1:0] med
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int IDX_W = AGE_W;

  // Stored cells and fill count.
  logic signed [SAMPLE_W-1:0] val [WINDOW_MAX];
  logic [AGE_W-1:0]           age [WINDOW_MAX];
  logic [CNT_W-1:0]           fill;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] fill_c;
  logic [CNT_W-1:0] cfill;
  logic [CNT_W-1:0] rank;
  logic             full;
  logic             any_hit;

  logic [WINDOW_MAX-1:0] hit_v;
  logic [WINDOW_MAX-1:0] sh_v;
  logic [WINDOW_MAX-1:0] ga_v;
  logic [WINDOW_MAX-1:0] cgt_v;
  logic [WINDOW_MAX-1:0] stay_v;

  logic signed [SAMPLE_W-1:0] cval [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] nval [WINDOW_MAX];
  logic [AGE_W-1:0]           cage [WINDOW_MAX];
  logic [AGE_W-1:0]           nage [WINDOW_MAX];

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    if (window_len == '0) begin
      len = CNT_W'(1);
    end else if (int'(window_len) > WINDOW_MAX) begin
      len = CNT_W'(WINDOW_MAX);
    end else begin
      len = CNT_W'(window_len);
    end
  end

  assign fill_c = (fill > len) ? len : fill;
  assign full   = (fill_c == len);

  // Per cell: is it the oldest entry, and is it above the new sample.
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_probe
    assign hit_v[j] = (CNT_W'(j) < fill_c) && (CNT_W'(age[j]) == len - CNT_W'(1));
    assign ga_v[j]  = val[j] > sample;
  end

  assign any_hit = |hit_v;

  // Drop the oldest entry by shifting the cells above it down one place.
  // Without an oldest entry the last sorted entry goes instead.
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_drop
    localparam logic [WINDOW_MAX-1:0] LE_MASK = {WINDOW_MAX{1'b1}} >> (WINDOW_MAX - 1 - j);
    assign sh_v[j] = full && (any_hit ? |(hit_v & LE_MASK) : (CNT_W'(j + 1) >= fill_c));
    if (j < WINDOW_MAX - 1) begin : g_mid
      assign cval[j]  = sh_v[j] ? val[j+1] : val[j];
      assign cage[j]  = (sh_v[j] ? age[j+1] : age[j]) + AGE_W'(1);
      assign cgt_v[j] = sh_v[j] ? ga_v[j+1] : ga_v[j];
    end else begin : g_top
      assign cval[j]  = val[j];
      assign cage[j]  = age[j] + AGE_W'(1);
      assign cgt_v[j] = ga_v[j];
    end
  end

  assign cfill = fill_c - CNT_W'(full);

  // Insert: cells not above the sample stay, the first other cell takes the
  // sample, and the rest move up one place. Equal values stay below.
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_ins
    assign stay_v[j] = (CNT_W'(j) < cfill) && !cgt_v[j];
    if (j == 0) begin : g_first
      assign nval[j] = stay_v[j] ? cval[j] : sample;
      assign nage[j] = stay_v[j] ? cage[j] : '0;
    end else begin : g_rest
      assign nval[j] = stay_v[j] ? cval[j] : (stay_v[j-1] ? sample : cval[j-1]);
      assign nage[j] = stay_v[j] ? cage[j] : (stay_v[j-1] ? '0 : cage[j-1]);
    end
  end

  // A result appears once the window is full after the insertion.
  assign emit = (cfill + CNT_W'(1) == len);
  assign rank = (len - CNT_W'(1)) >> 1;
  assign med  = nval[rank[IDX_W-1:0]];

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.restart) begin
      fill <= '0;
    end else if (ctrl.step) begin
      fill <= cfill + CNT_W'(1);
    end
  end

  // Cell contents.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
        val[j] <= nval[j];
        age[j] <= nage[j];
      end
    end
  end

  // The store never holds more entries than the window.
  `SWM_ASSERT(a_fill_le_len, fill <= len, "fill count exceeds window length")
  // Ages stay distinct, so at most one entry is the oldest.
  `SWM_ASSERT(a_oldest_unique, $onehot0(hit_v), "more than one oldest entry")
  // A result is produced only when the window ends up full.
  `SWM_ASSERT_NEXT(a_emit_full, ctrl.step && emit && !ctrl.restart, fill == len,
                   "result given with window not full")

endmodule

/* rtl/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter over the last window_len signed samples.
// ----------------------------------------------------------------------------
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the
// combinational sort-and-insert in the sorted store and the output register set this rate.
// After reset or a length write, no result comes until the window is full.
// Reset (synchronous, active high) empties the window and sets window_len to
// 16; a write to window_len empties the window as well.
// ----------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LEN_W-1:0]           window_len,
  // Sample input channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  // Median output channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] median
);

  logic [LEN_W-1:0]           cfg_len;
  swm_ctrl_t                  ctrl;
  logic                       emit;
  logic signed [SAMPLE_W-1:0] med;
  logic                       cfg_we;

  // Handshakes: a new item enters when the output slot is free or draining.
  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign in_ready     = !out_valid || out_ready;
  assign ctrl.step    = in_valid && in_ready;
  assign ctrl.restart = cfg_we;

  // Window length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= LEN_RESET;
    end else if (cfg_we) begin
      cfg_len <= window_len;
    end
  end

  swm_sorter #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .window_len (cfg_len),
    .sample     (sample),
    .emit       (emit),
    .med        (med)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && emit) begin
      median <= med;
    end
  end

  // An item that completes the window shows its result in the next cycle.
  `SWM_ASSERT_NEXT(a_emit_valid, ctrl.step && emit, out_valid,
                   "result of accepted item missing")
  `SWM_ASSERT_NEXT(a_emit_value, ctrl.step && emit, median == $past(med),
                   "result register holds the wrong median")
  // A length write lands in the length register.
  `SWM_ASSERT_NEXT(a_cfg_write, cfg_we, cfg_len == $past(window_len),
                   "window length write lost")

endmodule

/* dv/sliding_window_median_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Drives signed samples into the running median filter under random input
// gaps and output stalls, and rewrites the window length between phases.
// A local model keeps the recent samples in arrival order and picks the
// lower median of a full window. Each median is checked against it in order.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int WIN_CAP    = WINDOW_MAX_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 550;

  localparam logic signed [SAMPLE_W-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 32'sh8000_0000;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [LEN_W-1:0]           window_len = LEN_RESET;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample     = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] median;

  // Stimulus and model state.
  logic signed [SAMPLE_W-1:0] pending_samples[$];
  logic signed [SAMPLE_W-1:0] window_hist[$];
  logic signed [SAMPLE_W-1:0] expected_medians[$];
  int                         win_len    = 16;
  int                         err_count  = 0;
  int                         in_gap     = 0;
  int                         out_stall  = 0;
  bit                         in_steady  = 1'b0;
  bit                         out_steady = 1'b0;
  int                         idle_cycles = 0;

  sliding_window_median dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_len (window_len),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .median     (median)
  );

  always #2 clk = ~clk;

  // Mismatch reporting: one line per failure.
  task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                 input logic signed [SAMPLE_W-1:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Append one item to the stimulus queue.
  task automatic queue_item(input logic signed [SAMPLE_W-1:0] s);
    pending_samples = {pending_samples, s};
  endtask

  // Length actually used by the filter for a written register value.
  function automatic int clip_len(input logic [LEN_W-1:0] w);
    if (w == '0) return 1;
    if (int'(w) > WIN_CAP) return WIN_CAP;
    return int'(w);
  endfunction

  // Element of the given rank in the current window, by counting.
  function automatic logic signed [SAMPLE_W-1:0] select_rank(input int rank);
    int below;
    int upto;
    logic signed [SAMPLE_W-1:0] v;
    select_rank = '0;
    foreach (window_hist[i]) begin
      v = window_hist[i];
      below = 0;
      upto = 0;
      foreach (window_hist[j]) begin
        if (window_hist[j] < v) below++;
        if (window_hist[j] <= v) upto++;
      end
      if (below <= rank && rank < upto) select_rank = v;
    end
  endfunction

  // Add an accepted sample to the window and queue its median if full.
  task automatic predict_median(input logic signed [SAMPLE_W-1:0] s);
    window_hist = {window_hist, s};
    if (window_hist.size() > win_len) window_hist.delete(0);
    if (window_hist.size() == win_len) begin
      expected_medians = {expected_medians, select_rank((win_len - 1) / 2)};
    end
  endtask

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random sample: full range, clustered values with repeats, or extremes.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 82) return int'($urandom_range(0, 20)) - 10;
    case ($urandom_range(0, 5))
      0: return SMAX;
      1: return SMIN;
      2: return SMAX - 1;
      3: return SMIN + 1;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  // Wait until nothing is in flight, then let the pipeline settle. The check
  // runs at the falling edge, after the driver's updates have landed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write the window length while idle and restart the model window.
  task automatic write_window_len(input logic [LEN_W-1:0] w);
    wait_idle();
    @(posedge clk);
    cfg_valid  <= 1'b1;
    window_len <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_len = clip_len(w);
    window_hist.delete();
  endtask

  // Sample driver: feeds queued items with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) predict_median(sample);
      if ($urandom_range(0, 63) == 0) in_steady <= !in_steady;
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_samples.size() != 0) begin
          in_valid <= 1'b1;
          sample   <= pending_samples.pop_front();
          in_gap   <= pick_gap(in_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Median monitor: random back-pressure and in-order checking.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("median with no item waiting", median, '0);
        end else if (median !== expected_medians[0]) begin
          report_mismatch("median mismatch", median, expected_medians.pop_front());
        end else begin
          expected_medians.delete(0);
        end
      end
      if ($urandom_range(0, 63) == 0) out_steady <= !out_steady;
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap(out_steady);
      end
    end
  end

  // Watchdog on cycles with no accepted item on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sliding_window_median_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    logic signed [SAMPLE_W-1:0] fill_set[18] = '{SMAX, SMIN, 0, -1, 1, 32'sh5555_5555,
                                                 32'shAAAA_AAAA, SMAX, SMIN, 7, 7, 7, -7, 3,
                                                 SMIN + 1, SMAX - 1, SMIN, SMIN};
    logic [LEN_W-1:0] len_plan[10] = '{5'd16, 5'd31, 5'd17, 5'd3, 5'd15, 5'd8, 5'd1,
                                       5'd4, 5'd0, 5'd2};
    int rand_total;
    int phase;
    int count;
    logic [LEN_W-1:0] next_len;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset length of 16 with extremes and repeats.
    foreach (fill_set[i]) queue_item(fill_set[i]);

    // Directed: length 1 passes samples through.
    write_window_len(5'd1);
    queue_item(SMAX);
    queue_item(SMIN);

    // Directed: length 0 acts as length 1.
    write_window_len(5'd0);
    queue_item(-1);
    queue_item(0);

    // Directed: length 2 takes the lower of two equal samples.
    write_window_len(5'd2);
    queue_item(4);
    queue_item(4);

    // Random phases over planned lengths, then random lengths.
    rand_total = 0;
    phase = 0;
    while (rand_total < RAND_ITEMS) begin
      next_len = (phase < 10) ? len_plan[phase] : LEN_W'($urandom_range(0, 31));
      write_window_len(next_len);
      count = $urandom_range(35, 60);
      repeat (count) queue_item(rand_sample());
      rand_total += count;
      phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_medians.size() == 0) begin
      $display("sliding_window_median_tb: clean");
    end else begin
      $display("sliding_window_median_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_sorter.sv
rtl/sliding_window_median.sv
dv/sliding_window_median_tb.sv
